// ----- rtl/bvaa_pkg.sv -----
`timescale 1ns / 1ps
// Package for the body velocity and air angles unit: widths, stage indexes,
// the CORDIC arctangent table and the reset value of the speed of sound.
// No dependencies.
package bvaa_pkg;

   localparam int unsigned ROT_W    = 16;
   localparam int unsigned VEL_W    = 24;
   localparam int unsigned PROD_W   = ROT_W + VEL_W;
   localparam int unsigned SQ_W     = 48;
   localparam int unsigned ROOT_W   = 49;
   localparam int unsigned CORDIC_W = 36;
   localparam int unsigned ACC_W    = 32;
   localparam int unsigned ANG_W    = 16;
   localparam int unsigned MACH_W   = 16;
   localparam int unsigned DIVR_W   = 40;

   localparam int unsigned CORDIC_STEPS = 28;
   localparam int unsigned ROOT_STEPS   = 24;
   localparam int unsigned QUOT_STEPS   = 16;

   // Pipeline stage indexes.
   localparam int unsigned ST_IN      = 0;
   localparam int unsigned ST_MUL     = 1;
   localparam int unsigned ST_BODY    = 2;
   localparam int unsigned ST_SQ      = 3;
   localparam int unsigned ST_SUM     = 4;
   localparam int unsigned ST_ROOT0   = 5;
   localparam int unsigned ST_SPD     = ST_ROOT0 + ROOT_STEPS;
   localparam int unsigned ST_DIV0    = ST_SPD + 1;
   localparam int unsigned ST_DIVEND  = ST_DIV0 + QUOT_STEPS;
   localparam int unsigned ST_CORD0   = ST_SQ;
   localparam int unsigned ST_CORDEND = ST_CORD0 + CORDIC_STEPS;
   localparam int unsigned ST_ANG     = ST_CORDEND + 1;
   localparam int unsigned ST_OUT     = ST_DIVEND + 1;

   localparam logic [VEL_W-1:0] SOS_RESET = 24'd87040;

   typedef logic [ACC_W-1:0] acc_type;

   localparam acc_type ATAN_TABLE [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005
   };

endpackage

// ----- rtl/body_velocity_air_angles_unit.sv -----
`timescale 1ns / 1ps
// Top level of the body velocity and air angles unit: matrix rotation, norm,
// CORDIC air angles and Mach division in one stall-together pipeline.
// Depends on bvaa_pkg.
//
// Channel   Direction  Handshake               Content
// req_      in         req_valid / req_ready   3x3 Q2.14 matrix, local velocity
// rsp_      out        rsp_valid / rsp_ready   body velocity, speed, angles, Mach
// csr_      in         csr_valid / csr_ready   speed of sound (1/256 m/s)
//
// Every transfer walks through 48 register stages before its result leaves;
// the chain of square-root steps followed by the Mach quotient steps sets
// that depth. One request is taken per cycle while the output is not stalled.
// All stages advance together whenever the output register is empty or its
// result is taken; a stall freezes every stage, so nothing is lost or repeated.
// Reset empties the pipeline and loads 340 m/s as speed of sound.
module body_velocity_air_angles_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [15:0]  req_rot_00,
   input  logic signed [15:0]  req_rot_01,
   input  logic signed [15:0]  req_rot_02,
   input  logic signed [15:0]  req_rot_10,
   input  logic signed [15:0]  req_rot_11,
   input  logic signed [15:0]  req_rot_12,
   input  logic signed [15:0]  req_rot_20,
   input  logic signed [15:0]  req_rot_21,
   input  logic signed [15:0]  req_rot_22,
   input  logic signed [23:0]  req_vel_x,
   input  logic signed [23:0]  req_vel_y,
   input  logic signed [23:0]  req_vel_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [23:0]  rsp_body_vel_x,
   output logic signed [23:0]  rsp_body_vel_y,
   output logic signed [23:0]  rsp_body_vel_z,
   output logic        [23:0]  rsp_speed,
   output logic signed [15:0]  rsp_attack_angle,
   output logic signed [15:0]  rsp_sideslip_angle,
   output logic        [15:0]  rsp_mach,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic        [23:0]  csr_speed_of_sound
);

   localparam int unsigned LAST = bvaa_pkg::ST_OUT;

   // Stage valid bits and the common advance enable.
   logic [LAST:0] v_ff;
   logic          adv;

   logic [bvaa_pkg::VEL_W-1:0] sos_ff;

   // Input stage.
   logic signed [bvaa_pkg::ROT_W-1:0] rot_ff [9];
   logic signed [bvaa_pkg::VEL_W-1:0] vel_ff [3];

   // Products and body components (body kept along to the output).
   logic signed [bvaa_pkg::PROD_W-1:0] prod_ff [9];
   logic signed [bvaa_pkg::VEL_W-1:0]  body_in [3];
   logic signed [bvaa_pkg::VEL_W-1:0]  bd_ff [3][bvaa_pkg::ST_BODY:LAST];

   // Squares and square-root steps; stage ST_SUM holds the sum of squares.
   logic [bvaa_pkg::SQ_W-1:0]   sq_ff [3];
   logic [bvaa_pkg::SQ_W-1:0]   sn_in [bvaa_pkg::ST_SUM:bvaa_pkg::ST_SPD-1];
   logic [bvaa_pkg::SQ_W-1:0]   sn_ff [bvaa_pkg::ST_SUM:bvaa_pkg::ST_SPD-1];
   logic [bvaa_pkg::ROOT_W-1:0] sr_in [bvaa_pkg::ST_SUM:bvaa_pkg::ST_SPD-1];
   logic [bvaa_pkg::ROOT_W-1:0] sr_ff [bvaa_pkg::ST_SUM:bvaa_pkg::ST_SPD-1];
   logic [bvaa_pkg::VEL_W-1:0]  spd_in;
   logic [bvaa_pkg::VEL_W-1:0]  spd_ff [bvaa_pkg::ST_SPD:LAST];

   // Mach quotient steps; stage ST_DIV0 holds the dividend and overflow flag.
   logic [bvaa_pkg::DIVR_W-1:0] dr_in [bvaa_pkg::ST_DIV0:bvaa_pkg::ST_DIVEND];
   logic [bvaa_pkg::DIVR_W-1:0] dr_ff [bvaa_pkg::ST_DIV0:bvaa_pkg::ST_DIVEND];
   logic [bvaa_pkg::MACH_W-1:0] dq_in [bvaa_pkg::ST_DIV0:bvaa_pkg::ST_DIVEND];
   logic [bvaa_pkg::MACH_W-1:0] dq_ff [bvaa_pkg::ST_DIV0:bvaa_pkg::ST_DIVEND];
   logic                        ds_in [bvaa_pkg::ST_DIV0:bvaa_pkg::ST_DIVEND];
   logic                        ds_ff [bvaa_pkg::ST_DIV0:bvaa_pkg::ST_DIVEND];
   logic [bvaa_pkg::MACH_W-1:0] mach_ff;

   // Two CORDIC lanes: lane 0 works on (x, z), lane 1 on (x, y).
   logic signed [bvaa_pkg::CORDIC_W-1:0] cx_in [2][bvaa_pkg::ST_CORD0:bvaa_pkg::ST_CORDEND];
   logic signed [bvaa_pkg::CORDIC_W-1:0] cx_ff [2][bvaa_pkg::ST_CORD0:bvaa_pkg::ST_CORDEND];
   logic signed [bvaa_pkg::CORDIC_W-1:0] cy_in [2][bvaa_pkg::ST_CORD0:bvaa_pkg::ST_CORDEND];
   logic signed [bvaa_pkg::CORDIC_W-1:0] cy_ff [2][bvaa_pkg::ST_CORD0:bvaa_pkg::ST_CORDEND];
   bvaa_pkg::acc_type                    ca_in [2][bvaa_pkg::ST_CORD0:bvaa_pkg::ST_CORDEND];
   bvaa_pkg::acc_type                    ca_ff [2][bvaa_pkg::ST_CORD0:bvaa_pkg::ST_CORDEND];
   logic                                 cz_ff [2][bvaa_pkg::ST_CORD0:bvaa_pkg::ST_CORDEND];
   logic [bvaa_pkg::ANG_W-1:0]           ang_in [2];
   logic [bvaa_pkg::ANG_W-1:0]           aa_ff [2][bvaa_pkg::ST_ANG:LAST];

   logic [bvaa_pkg::VEL_W-1:0] abs_bx;

   // Handshakes: the whole pipeline moves when the output register frees up.
   assign adv       = !v_ff[LAST] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = v_ff[LAST];
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= '0;
         sos_ff <= bvaa_pkg::SOS_RESET;
      end else begin
         if (adv) begin
            v_ff <= {v_ff[LAST-1:0], req_valid};
         end
         if (csr_valid) begin
            sos_ff <= csr_speed_of_sound;
         end
      end
   end

   // Rounded, saturated row dot product.
   function automatic logic signed [23:0] row_round(
      input logic signed [39:0] p0,
      input logic signed [39:0] p1,
      input logic signed [39:0] p2
   );
      logic signed [42:0] s;
      logic signed [28:0] r;
      s = 43'(p0) + 43'(p1) + 43'(p2) + 43'sd8192;
      r = 29'(s >>> 14);
      if (r > 29'sd8388607) begin
         row_round = 24'sh7FFFFF;
      end else if (r < -29'sd8388608) begin
         row_round = 24'sh800000;
      end else begin
         row_round = r[23:0];
      end
   endfunction

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         body_in[r] = row_round(prod_ff[3*r], prod_ff[3*r+1], prod_ff[3*r+2]);
      end
   end

   // Square-root steps: one result bit per stage, restoring form.
   always_comb begin
      logic [bvaa_pkg::SQ_W-1:0]   bitv;
      logic [bvaa_pkg::ROOT_W-1:0] cand;
      sn_in[bvaa_pkg::ST_SUM] = 48'(sq_ff[0]) + 48'(sq_ff[1]) + 48'(sq_ff[2]);
      sr_in[bvaa_pkg::ST_SUM] = '0;
      for (int j = 0; j < bvaa_pkg::ROOT_STEPS; j++) begin
         bitv = 48'(1) << (46 - 2*j);
         cand = sr_ff[bvaa_pkg::ST_SUM+j] + {1'b0, bitv};
         if ({1'b0, sn_ff[bvaa_pkg::ST_SUM+j]} >= cand) begin
            sn_in[bvaa_pkg::ST_ROOT0+j] = sn_ff[bvaa_pkg::ST_SUM+j] - cand[47:0];
            sr_in[bvaa_pkg::ST_ROOT0+j] = (sr_ff[bvaa_pkg::ST_SUM+j] >> 1) + {1'b0, bitv};
         end else begin
            sn_in[bvaa_pkg::ST_ROOT0+j] = sn_ff[bvaa_pkg::ST_SUM+j];
            sr_in[bvaa_pkg::ST_ROOT0+j] = sr_ff[bvaa_pkg::ST_SUM+j] >> 1;
         end
      end
   end

   // Round to nearest: step up when the remainder exceeds the root.
   always_comb begin
      logic [24:0] up;
      up = sr_ff[bvaa_pkg::ST_SPD-1][24:0]
         + 25'({1'b0, sn_ff[bvaa_pkg::ST_SPD-1]} > sr_ff[bvaa_pkg::ST_SPD-1]);
      spd_in = up[24] ? 24'hFFFFFF : up[23:0];
   end

   // Mach: restoring division with an overflow check up front.
   always_comb begin
      logic [bvaa_pkg::DIVR_W-1:0] dvs;
      dr_in[bvaa_pkg::ST_DIV0] = {8'd0, spd_ff[bvaa_pkg::ST_SPD], 8'd0}
                               + {17'd0, sos_ff[23:1]};
      ds_in[bvaa_pkg::ST_DIV0] = dr_in[bvaa_pkg::ST_DIV0] >= ({16'd0, sos_ff} << 16);
      dq_in[bvaa_pkg::ST_DIV0] = '0;
      for (int j = 0; j < bvaa_pkg::QUOT_STEPS; j++) begin
         dvs = {16'd0, sos_ff} << (15 - j);
         ds_in[bvaa_pkg::ST_DIV0+1+j] = ds_ff[bvaa_pkg::ST_DIV0+j];
         if (dr_ff[bvaa_pkg::ST_DIV0+j] >= dvs) begin
            dr_in[bvaa_pkg::ST_DIV0+1+j] = dr_ff[bvaa_pkg::ST_DIV0+j] - dvs;
            dq_in[bvaa_pkg::ST_DIV0+1+j] = dq_ff[bvaa_pkg::ST_DIV0+j]
                                         | (16'd1 << (15 - j));
         end else begin
            dr_in[bvaa_pkg::ST_DIV0+1+j] = dr_ff[bvaa_pkg::ST_DIV0+j];
            dq_in[bvaa_pkg::ST_DIV0+1+j] = dq_ff[bvaa_pkg::ST_DIV0+j];
         end
      end
   end

   // CORDIC vectoring: entry folds the left half plane, then one micro
   // rotation per stage drives y toward zero.
   always_comb begin
      logic signed [bvaa_pkg::CORDIC_W-1:0] xs;
      logic signed [bvaa_pkg::CORDIC_W-1:0] ys;
      logic signed [bvaa_pkg::CORDIC_W-1:0] dx;
      logic signed [bvaa_pkg::CORDIC_W-1:0] dy;
      bvaa_pkg::acc_type                    a;
      for (int u = 0; u < 2; u++) begin
         xs = 36'(bd_ff[0][bvaa_pkg::ST_BODY]) <<< 8;
         ys = 36'(bd_ff[2-u][bvaa_pkg::ST_BODY]) <<< 8;
         if (xs < 0) begin
            cx_in[u][bvaa_pkg::ST_CORD0] = -xs;
            cy_in[u][bvaa_pkg::ST_CORD0] = -ys;
            ca_in[u][bvaa_pkg::ST_CORD0] = 32'h80000000;
         end else begin
            cx_in[u][bvaa_pkg::ST_CORD0] = xs;
            cy_in[u][bvaa_pkg::ST_CORD0] = ys;
            ca_in[u][bvaa_pkg::ST_CORD0] = '0;
         end
         for (int i = 0; i < bvaa_pkg::CORDIC_STEPS; i++) begin
            dx = cy_ff[u][bvaa_pkg::ST_CORD0+i] >>> i;
            dy = cx_ff[u][bvaa_pkg::ST_CORD0+i] >>> i;
            if (cy_ff[u][bvaa_pkg::ST_CORD0+i] < 0) begin
               cx_in[u][bvaa_pkg::ST_CORD0+1+i] = cx_ff[u][bvaa_pkg::ST_CORD0+i] - dx;
               cy_in[u][bvaa_pkg::ST_CORD0+1+i] = cy_ff[u][bvaa_pkg::ST_CORD0+i] + dy;
               ca_in[u][bvaa_pkg::ST_CORD0+1+i] = ca_ff[u][bvaa_pkg::ST_CORD0+i]
                                                - bvaa_pkg::ATAN_TABLE[i];
            end else begin
               cx_in[u][bvaa_pkg::ST_CORD0+1+i] = cx_ff[u][bvaa_pkg::ST_CORD0+i] + dx;
               cy_in[u][bvaa_pkg::ST_CORD0+1+i] = cy_ff[u][bvaa_pkg::ST_CORD0+i] - dy;
               ca_in[u][bvaa_pkg::ST_CORD0+1+i] = ca_ff[u][bvaa_pkg::ST_CORD0+i]
                                                + bvaa_pkg::ATAN_TABLE[i];
            end
         end
         // Round to 16 bits; a zero vector gives angle zero. Lane 0 is negated
         // modulo 2^16 for the angle of attack.
         a = ca_ff[u][bvaa_pkg::ST_CORDEND] + 32'h00008000;
         if (cz_ff[u][bvaa_pkg::ST_CORDEND]) begin
            ang_in[u] = '0;
         end else if (u == 0) begin
            ang_in[u] = 16'd0 - a[31:16];
         end else begin
            ang_in[u] = a[31:16];
         end
      end
   end

   // Payload registers: no reset, move with the common enable.
   always_ff @(posedge clock) begin
      if (adv) begin
         rot_ff[0] <= req_rot_00;
         rot_ff[1] <= req_rot_01;
         rot_ff[2] <= req_rot_02;
         rot_ff[3] <= req_rot_10;
         rot_ff[4] <= req_rot_11;
         rot_ff[5] <= req_rot_12;
         rot_ff[6] <= req_rot_20;
         rot_ff[7] <= req_rot_21;
         rot_ff[8] <= req_rot_22;
         vel_ff[0] <= req_vel_x;
         vel_ff[1] <= req_vel_y;
         vel_ff[2] <= req_vel_z;
         for (int k = 0; k < 9; k++) begin
            prod_ff[k] <= 40'(rot_ff[k]) * 40'(vel_ff[k % 3]);
         end
         for (int r = 0; r < 3; r++) begin
            bd_ff[r][bvaa_pkg::ST_BODY] <= body_in[r];
            for (int s = bvaa_pkg::ST_BODY + 1; s <= LAST; s++) begin
               bd_ff[r][s] <= bd_ff[r][s-1];
            end
            sq_ff[r] <= 48'(bd_ff[r][bvaa_pkg::ST_BODY] * bd_ff[r][bvaa_pkg::ST_BODY]);
         end
         for (int s = bvaa_pkg::ST_SUM; s < bvaa_pkg::ST_SPD; s++) begin
            sn_ff[s] <= sn_in[s];
            sr_ff[s] <= sr_in[s];
         end
         spd_ff[bvaa_pkg::ST_SPD] <= spd_in;
         for (int s = bvaa_pkg::ST_SPD + 1; s <= LAST; s++) begin
            spd_ff[s] <= spd_ff[s-1];
         end
         for (int s = bvaa_pkg::ST_DIV0; s <= bvaa_pkg::ST_DIVEND; s++) begin
            dr_ff[s] <= dr_in[s];
            dq_ff[s] <= dq_in[s];
            ds_ff[s] <= ds_in[s];
         end
         mach_ff <= ds_ff[bvaa_pkg::ST_DIVEND] ? 16'hFFFF : dq_ff[bvaa_pkg::ST_DIVEND];
         for (int u = 0; u < 2; u++) begin
            cz_ff[u][bvaa_pkg::ST_CORD0] <= (bd_ff[0][bvaa_pkg::ST_BODY] == '0)
                                         && (bd_ff[2-u][bvaa_pkg::ST_BODY] == '0);
            for (int s = bvaa_pkg::ST_CORD0; s <= bvaa_pkg::ST_CORDEND; s++) begin
               cx_ff[u][s] <= cx_in[u][s];
               cy_ff[u][s] <= cy_in[u][s];
               ca_ff[u][s] <= ca_in[u][s];
            end
            for (int s = bvaa_pkg::ST_CORD0 + 1; s <= bvaa_pkg::ST_CORDEND; s++) begin
               cz_ff[u][s] <= cz_ff[u][s-1];
            end
            aa_ff[u][bvaa_pkg::ST_ANG] <= ang_in[u];
            for (int s = bvaa_pkg::ST_ANG + 1; s <= LAST; s++) begin
               aa_ff[u][s] <= aa_ff[u][s-1];
            end
         end
      end
   end

   assign rsp_body_vel_x     = bd_ff[0][LAST];
   assign rsp_body_vel_y     = bd_ff[1][LAST];
   assign rsp_body_vel_z     = bd_ff[2][LAST];
   assign rsp_speed          = spd_ff[LAST];
   assign rsp_attack_angle   = aa_ff[0][LAST];
   assign rsp_sideslip_angle = aa_ff[1][LAST];
   assign rsp_mach           = mach_ff;

   assign abs_bx = rsp_body_vel_x[23] ? 24'(-rsp_body_vel_x) : rsp_body_vel_x;

   // A stall must freeze the valid chain.
   a_stall_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> v_ff == $past(v_ff))
      else $error("valid chain moved during a stall");

   // The norm never falls below the magnitude of the x component.
   a_speed_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_speed >= abs_bx)
      else $error("speed below body x magnitude");

   // A zero body vector gives zero speed, angles and Mach.
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_body_vel_x == '0 && rsp_body_vel_y == '0
      && rsp_body_vel_z == '0 && sos_ff != '0
      |-> rsp_speed == '0 && rsp_attack_angle == '0
          && rsp_sideslip_angle == '0 && rsp_mach == '0)
      else $error("nonzero result for a zero body vector");

endmodule
